// ----- src/dsd_pkg.sv -----
// Shared types, constants and tables for the damped spectral division block.
// Used by dsd_ctrl, dsd_datapath and damped_spectral_division.
`timescale 1ns / 1ps
`default_nettype none

package dsd_pkg;

  localparam int COEFF_BITS  = 24;
  localparam int FRAC_W      = 17;
  localparam int CNT_W       = 14;
  localparam int MAX_SAMPLES = 8192;
  localparam int STEP_W      = 7;

  localparam int MUL_STEPS  = 9;
  localparam int DIV_STEPS  = 80;
  localparam int DAMP_STEPS = FRAC_W;
  localparam int SQ_STEPS   = 3;
  localparam int SQRT_STEPS = 32;
  localparam int COR_STEPS  = 17;

  localparam int PHASE_LIM = 23040;
  localparam int HALF_TURN = 180 * 65536;

  localparam logic [FRAC_W-1:0] DAMP_FRAC_RST = FRAC_W'(6554);
  localparam logic [CNT_W-1:0]  SAMPLE_CNT_RST = CNT_W'(1024);

  localparam logic CFG_DAMP_FRAC  = 1'b0;
  localparam logic CFG_SAMPLE_CNT = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_MUL,
    OP_ENERGY,
    OP_DIV_LOAD_E,
    OP_DIV_LOAD_RE,
    OP_DIV_LOAD_IM,
    OP_DIV_LOAD_RATIO,
    OP_DIV_STEP,
    OP_STORE_RE,
    OP_STORE_IM,
    OP_DAMP_STEP,
    OP_DAMP_STORE,
    OP_DEN,
    OP_SQ,
    OP_SQRT_LOAD_RATIO,
    OP_SQRT_STEP,
    OP_STORE_MAG,
    OP_STORE_RATIO,
    OP_COR_LOAD,
    OP_COR_STEP,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [STEP_W-1:0] step;
  } dsd_cmd_t;

  typedef struct packed {
    logic is_divide;
    logic is_last;
    logic out_free;
  } dsd_stat_t;

  // arctangent of 2^-i in 1/65536 degree
  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] v;
    unique case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // quotient magnitude to signed Q16.16 with saturation; result {sat, value}
  function automatic logic [32:0] sat_part(input logic neg, input logic [79:0] q);
    logic big;
    logic [32:0] r;
    big = |q[79:32];
    if (!neg) begin
      if (big || q[31]) r = {1'b1, 32'h7FFF_FFFF};
      else              r = {1'b0, q[31:0]};
    end else begin
      if (big || (q[31] && (|q[30:0]))) r = {1'b1, 32'h8000_0000};
      else                              r = {1'b0, 32'(-q[31:0])};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- src/dsd_ctrl.sv -----
// Sequencer for the damped spectral division block.
// At most one datapath command a cycle; needs dsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsd_ctrl
  import dsd_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire dsd_stat_t stat_i,
  output dsd_cmd_t       cmd_o
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_MUL    = 5'd1;
  localparam logic [4:0] ST_ENERGY = 5'd2;
  localparam logic [4:0] ST_DLE    = 5'd3;
  localparam logic [4:0] ST_DIVE   = 5'd4;
  localparam logic [4:0] ST_DAMP   = 5'd5;
  localparam logic [4:0] ST_DSTORE = 5'd6;
  localparam logic [4:0] ST_DEN    = 5'd7;
  localparam logic [4:0] ST_DLRE   = 5'd8;
  localparam logic [4:0] ST_DIVRE  = 5'd9;
  localparam logic [4:0] ST_SRE    = 5'd10;
  localparam logic [4:0] ST_DLIM   = 5'd11;
  localparam logic [4:0] ST_DIVIM  = 5'd12;
  localparam logic [4:0] ST_SIM    = 5'd13;
  localparam logic [4:0] ST_SQ     = 5'd14;
  localparam logic [4:0] ST_SQRT1  = 5'd15;
  localparam logic [4:0] ST_SMAG   = 5'd16;
  localparam logic [4:0] ST_DLRA   = 5'd17;
  localparam logic [4:0] ST_DIVRA  = 5'd18;
  localparam logic [4:0] ST_SQRA   = 5'd19;
  localparam logic [4:0] ST_SQRT2  = 5'd20;
  localparam logic [4:0] ST_SRA    = 5'd21;
  localparam logic [4:0] ST_CLOAD  = 5'd22;
  localparam logic [4:0] ST_COR    = 5'd23;
  localparam logic [4:0] ST_FIN    = 5'd24;

  logic [4:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    cmd_o.step = step_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LATCH;
          step_d   = '0;
          state_d  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.op = OP_MUL;
        if (step_q == STEP_W'(MUL_STEPS - 1)) begin
          step_d  = '0;
          state_d = stat_i.is_divide ? ST_DEN : ST_ENERGY;
        end else step_d = step_q + 1'b1;
      end
      ST_ENERGY: begin
        cmd_o.op = OP_ENERGY;
        state_d  = stat_i.is_last ? ST_DLE : ST_IDLE;
      end
      ST_DLE: begin
        cmd_o.op = OP_DIV_LOAD_E;
        state_d  = ST_DIVE;
      end
      ST_DIVE: begin
        cmd_o.op = OP_DIV_STEP;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_DAMP;
        end else step_d = step_q + 1'b1;
      end
      ST_DAMP: begin
        cmd_o.op = OP_DAMP_STEP;
        if (step_q == STEP_W'(DAMP_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_DSTORE;
        end else step_d = step_q + 1'b1;
      end
      ST_DSTORE: begin
        cmd_o.op = OP_DAMP_STORE;
        state_d  = ST_IDLE;
      end
      ST_DEN: begin
        cmd_o.op = OP_DEN;
        state_d  = ST_DLRE;
      end
      ST_DLRE: begin
        cmd_o.op = OP_DIV_LOAD_RE;
        state_d  = ST_DIVRE;
      end
      ST_DIVRE: begin
        cmd_o.op = OP_DIV_STEP;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_SRE;
        end else step_d = step_q + 1'b1;
      end
      ST_SRE: begin
        cmd_o.op = OP_STORE_RE;
        state_d  = ST_DLIM;
      end
      ST_DLIM: begin
        cmd_o.op = OP_DIV_LOAD_IM;
        state_d  = ST_DIVIM;
      end
      ST_DIVIM: begin
        cmd_o.op = OP_DIV_STEP;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_SIM;
        end else step_d = step_q + 1'b1;
      end
      ST_SIM: begin
        cmd_o.op = OP_STORE_IM;
        state_d  = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.op = OP_SQ;
        if (step_q == STEP_W'(SQ_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_SQRT1;
        end else step_d = step_q + 1'b1;
      end
      ST_SQRT1: begin
        cmd_o.op = OP_SQRT_STEP;
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_SMAG;
        end else step_d = step_q + 1'b1;
      end
      ST_SMAG: begin
        cmd_o.op = OP_STORE_MAG;
        state_d  = ST_DLRA;
      end
      ST_DLRA: begin
        cmd_o.op = OP_DIV_LOAD_RATIO;
        state_d  = ST_DIVRA;
      end
      ST_DIVRA: begin
        cmd_o.op = OP_DIV_STEP;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_SQRA;
        end else step_d = step_q + 1'b1;
      end
      ST_SQRA: begin
        cmd_o.op = OP_SQRT_LOAD_RATIO;
        state_d  = ST_SQRT2;
      end
      ST_SQRT2: begin
        cmd_o.op = OP_SQRT_STEP;
        if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_SRA;
        end else step_d = step_q + 1'b1;
      end
      ST_SRA: begin
        cmd_o.op = OP_STORE_RATIO;
        state_d  = ST_CLOAD;
      end
      ST_CLOAD: begin
        cmd_o.op = OP_COR_LOAD;
        state_d  = ST_COR;
      end
      ST_COR: begin
        cmd_o.op = OP_COR_STEP;
        if (step_q == STEP_W'(COR_STEPS - 1)) begin
          step_d  = '0;
          state_d = ST_FIN;
        end else step_d = step_q + 1'b1;
      end
      ST_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        step_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/dsd_datapath.sv -----
// Datapath: multiplier, restoring divider, square root, CORDIC and result stage.
// Driven by dsd_ctrl commands; depends on dsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsd_datapath
  import dsd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dsd_cmd_t              cmd_i,
  output dsd_stat_t                  stat_o,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_addr_i,
  input  wire logic [FRAC_W-1:0]     cfg_wdata_i,
  input  wire logic [4*COEFF_BITS-1:0] in_data_i,
  input  wire logic                  in_kind_i,
  input  wire logic                  in_last_i,
  output logic [143:0]               out_data_o,
  output logic                       out_zero_o,
  output logic                       out_last_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i
);

  // config and persistent state
  logic [FRAC_W-1:0] df_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [63:0]       energy_q;
  logic [63:0]       damp_q;
  logic              tvalid_q;

  // latched item
  logic signed [COEFF_BITS-1:0] ir_q, ii_q, orl_q, oim_q;
  logic kind_q, last_q;

  // working registers
  logic signed [65:0] prod_q;
  logic [47:0]        ipow_q, opow_q;
  logic signed [48:0] nr_q, ni_q;
  logic [63:0]        den_q;
  logic [79:0]        dvd_q, quo_q;
  logic [63:0]        dvs_q, rem_q;
  logic [80:0]        acc_q;
  logic [63:0]        sv_q, sres_q, sbit_q;
  logic signed [51:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic [31:0]        re_q, im_q, mag_q, ratio_q;
  logic               sat_re_q, sat_im_q, rovf_q;

  // output register
  logic [143:0] odata_q;
  logic         ozero_q, olast_q;

  logic signed [32:0] mul_a, mul_b;
  logic [64:0]        rem_sh, rem_nx, esum, dsum;
  logic               ge;
  logic [CNT_W-1:0]   cnt_eff;
  logic [47:0]        nr_mag, ni_mag;
  logic [63:0]        sq_t;
  logic signed [51:0] xs, ys;
  logic signed [32:0] ph_t, ph_s;
  logic [15:0]        phase;
  logic [32:0]        sp_re, sp_im;
  logic               den_zero;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == OP_SQ) begin
      if (cmd_i.step == '0) begin
        mul_a = {re_q[31], re_q};
        mul_b = {re_q[31], re_q};
      end else begin
        mul_a = {im_q[31], im_q};
        mul_b = {im_q[31], im_q};
      end
    end else begin
      unique case (cmd_i.step[2:0])
        3'd0: begin mul_a = 33'(ir_q);  mul_b = 33'(ir_q); end
        3'd1: begin mul_a = 33'(ii_q);  mul_b = 33'(ii_q); end
        3'd2: begin mul_a = 33'(orl_q); mul_b = 33'(orl_q); end
        3'd3: begin mul_a = 33'(oim_q); mul_b = 33'(oim_q); end
        3'd4: begin mul_a = 33'(orl_q); mul_b = 33'(ir_q); end
        3'd5: begin mul_a = 33'(oim_q); mul_b = 33'(ii_q); end
        3'd6: begin mul_a = 33'(oim_q); mul_b = 33'(ir_q); end
        default: begin mul_a = 33'(orl_q); mul_b = 33'(ii_q); end
      endcase
    end
  end

  assign rem_sh = {rem_q, dvd_q[79]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_nx = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

  assign esum = {1'b0, energy_q} + {17'b0, ipow_q};
  assign dsum = {1'b0, damp_q} + {17'b0, ipow_q};

  always_comb begin
    cnt_eff = cnt_q;
    if (cnt_q == '0) cnt_eff = CNT_W'(1);
    else if (cnt_q > CNT_W'(MAX_SAMPLES)) cnt_eff = CNT_W'(MAX_SAMPLES);
  end

  assign nr_mag = nr_q[48] ? 48'(-nr_q) : nr_q[47:0];
  assign ni_mag = ni_q[48] ? 48'(-ni_q) : ni_q[47:0];

  assign sq_t = sres_q + sbit_q;

  assign xs = cx_q >>> cmd_i.step[4:0];
  assign ys = cy_q >>> cmd_i.step[4:0];

  assign ph_t = 33'sd256 - {cz_q[31], cz_q};
  assign ph_s = ph_t >>> 9;
  always_comb begin
    if (ph_s > 33'sd23040)       phase = 16'(PHASE_LIM);
    else if (ph_s < -33'sd23040) phase = 16'(-PHASE_LIM);
    else                         phase = ph_s[15:0];
  end

  assign sp_re    = sat_part(nr_q[48], quo_q);
  assign sp_im    = sat_part(ni_q[48], quo_q);
  assign den_zero = den_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      df_q     <= DAMP_FRAC_RST;
      cnt_q    <= SAMPLE_CNT_RST;
      energy_q <= '0;
      damp_q   <= '0;
      tvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_DAMP_FRAC) df_q <= cfg_wdata_i;
        else                             cnt_q <= cfg_wdata_i[CNT_W-1:0];
      end
      if (cmd_i.op == OP_ENERGY) energy_q <= esum[64] ? '1 : esum[63:0];
      if (cmd_i.op == OP_DAMP_STORE) begin
        damp_q   <= acc_q[80] ? '1 : acc_q[79:16];
        energy_q <= '0;
      end
      if (cmd_i.op == OP_OUT)           tvalid_q <= 1'b1;
      else if (out_ready_i)             tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      OP_LATCH: begin
        ir_q   <= in_data_i[COEFF_BITS-1:0];
        ii_q   <= in_data_i[2*COEFF_BITS-1:COEFF_BITS];
        orl_q  <= in_data_i[3*COEFF_BITS-1:2*COEFF_BITS];
        oim_q  <= in_data_i[4*COEFF_BITS-1:3*COEFF_BITS];
        kind_q <= in_kind_i;
        last_q <= in_last_i;
      end
      OP_MUL: begin
        unique case (cmd_i.step[3:0])
          4'd1: ipow_q <= prod_q[47:0];
          4'd2: ipow_q <= ipow_q + prod_q[47:0];
          4'd3: opow_q <= prod_q[47:0];
          4'd4: opow_q <= opow_q + prod_q[47:0];
          4'd5: nr_q <= prod_q[48:0];
          4'd6: nr_q <= nr_q + prod_q[48:0];
          4'd7: ni_q <= prod_q[48:0];
          4'd8: ni_q <= ni_q - prod_q[48:0];
          default: ;
        endcase
      end
      OP_DEN: den_q <= dsum[64] ? '1 : dsum[63:0];
      OP_DIV_LOAD_E: begin
        dvd_q <= {16'b0, energy_q};
        dvs_q <= {{(64-CNT_W){1'b0}}, cnt_eff};
        rem_q <= '0;
      end
      OP_DIV_LOAD_RE: begin
        dvd_q <= {16'b0, nr_mag, 16'b0};
        dvs_q <= den_q;
        rem_q <= '0;
      end
      OP_DIV_LOAD_IM: begin
        dvd_q <= {16'b0, ni_mag, 16'b0};
        dvs_q <= den_q;
        rem_q <= '0;
      end
      OP_DIV_LOAD_RATIO: begin
        dvd_q <= {opow_q, 32'b0};
        dvs_q <= {16'b0, ipow_q};
        rem_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q <= rem_nx[63:0];
        quo_q <= {quo_q[78:0], ge};
        dvd_q <= {dvd_q[78:0], 1'b0};
      end
      OP_DAMP_STEP: begin
        if (cmd_i.step == '0)
          acc_q <= df_q[0] ? {17'b0, quo_q[63:0]} : '0;
        else if (df_q[cmd_i.step[4:0]])
          acc_q <= acc_q + ({17'b0, quo_q[63:0]} << cmd_i.step[4:0]);
      end
      OP_STORE_RE: begin
        re_q     <= den_zero ? '0 : sp_re[31:0];
        sat_re_q <= !den_zero && sp_re[32];
      end
      OP_STORE_IM: begin
        im_q     <= den_zero ? '0 : sp_im[31:0];
        sat_im_q <= !den_zero && sp_im[32];
      end
      OP_SQ: begin
        if (cmd_i.step == STEP_W'(1)) sv_q <= prod_q[63:0];
        if (cmd_i.step == STEP_W'(2)) begin
          sv_q   <= sv_q + prod_q[63:0];
          sres_q <= '0;
          sbit_q <= 64'd1 << 62;
        end
      end
      OP_SQRT_LOAD_RATIO: begin
        sv_q   <= quo_q[63:0];
        rovf_q <= |quo_q[79:64];
        sres_q <= '0;
        sbit_q <= 64'd1 << 62;
      end
      OP_SQRT_STEP: begin
        if (sv_q >= sq_t) begin
          sv_q   <= sv_q - sq_t;
          sres_q <= (sres_q >> 1) + sbit_q;
        end else begin
          sres_q <= sres_q >> 1;
        end
        sbit_q <= sbit_q >> 2;
      end
      OP_STORE_MAG: begin
        if (den_zero)                  mag_q <= '0;
        else if (sat_re_q || sat_im_q) mag_q <= '1;
        else                           mag_q <= sres_q[31:0];
      end
      OP_STORE_RATIO: begin
        if (ipow_q == '0)  ratio_q <= (opow_q != '0) ? '1 : '0;
        else if (rovf_q)   ratio_q <= '1;
        else               ratio_q <= sres_q[31:0];
      end
      OP_COR_LOAD: begin
        if (nr_q[48]) begin
          cx_q <= -52'(nr_q);
          cy_q <= -52'(ni_q);
          cz_q <= ni_q[48] ? -32'sd11796480 : 32'sd11796480;
        end else begin
          cx_q <= 52'(nr_q);
          cy_q <= 52'(ni_q);
          cz_q <= '0;
        end
      end
      OP_COR_STEP: begin
        if (cy_q > 0) begin
          cx_q <= cx_q + ys;
          cy_q <= cy_q - xs;
          cz_q <= cz_q + 32'(atan_entry(cmd_i.step[4:0]));
        end else if (cy_q < 0) begin
          cx_q <= cx_q - ys;
          cy_q <= cy_q + xs;
          cz_q <= cz_q - 32'(atan_entry(cmd_i.step[4:0]));
        end
      end
      OP_OUT: begin
        odata_q <= {ratio_q, phase, mag_q, im_q, re_q};
        ozero_q <= (ipow_q == '0) || den_zero;
        olast_q <= last_q;
      end
      default: ;
    endcase
  end

  assign stat_o.is_divide = kind_q;
  assign stat_o.is_last   = last_q;
  assign stat_o.out_free  = !tvalid_q || out_ready_i;

  assign out_data_o  = odata_q;
  assign out_zero_o  = ozero_q;
  assign out_last_o  = olast_q;
  assign out_valid_o = tvalid_q;

endmodule

`default_nettype wire

// ----- src/damped_spectral_division.sv -----
// Top level of the damped spectral division block.
// Joins dsd_ctrl and dsd_datapath; depends on dsd_pkg.
//
// Measure beats (tuser 0) add |I|^2 to an energy sum; the measure beat with
// tlast set also divides the sum by sample_count (clamped to 1..8192) and
// scales it by damping_fraction. Divide beats (tuser 1) take three 80-step
// restoring divisions on one shared divider, two 32-step square roots and a
// 17-step CORDIC, one step a cycle. One beat is in work at a time; a finished
// result sits in the output register while the next beat is taken. Configuration
// writes take effect at once; the user must put them in while idle, which the block does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module damped_spectral_division
  import dsd_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // in_real, in_imag, out_real, out_imag
  input  wire logic [4*COEFF_BITS-1:0] s_axis_tdata_i,
  // command
  input  wire logic                    s_axis_tuser_i,
  input  wire logic                    s_axis_tlast_i,
  output logic                         m_axis_tvalid_o,
  input  wire logic                    m_axis_tready_i,
  // resp_real, resp_imag, resp_magnitude, resp_phase, direct_ratio
  output logic [143:0]                 m_axis_tdata_o,
  // zero_divisor
  output logic                         m_axis_tuser_o,
  output logic                         m_axis_tlast_o,
  input  wire logic                    cfg_we_i,
  input  wire logic                    cfg_addr_i,
  input  wire logic [FRAC_W-1:0]       cfg_wdata_i
);

  dsd_cmd_t  cmd;
  dsd_stat_t stat;

  dsd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dsd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (s_axis_tdata_i),
    .in_kind_i   (s_axis_tuser_i),
    .in_last_i   (s_axis_tlast_i),
    .out_data_o  (m_axis_tdata_o),
    .out_zero_o  (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i)
  );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for damped_spectral_division: directed table, then random
// measure/divide passes under several damping settings. Depends on dsd_pkg.
`timescale 1ns / 1ps

module testbench;
  import dsd_pkg::*;

  typedef struct packed {
    logic              cmd;
    logic signed [23:0] ir;
    logic signed [23:0] ii;
    logic signed [23:0] orl;
    logic signed [23:0] oim;
    logic              last;
  } bin_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic [31:0]        mag;
    logic signed [15:0] phase;
    logic [31:0]        ratio;
    logic               zero;
    logic               last;
  } resp_t;

  typedef struct packed {
    bin_t  b;
    logic  typed;
    resp_t r;
  } row_t;

  localparam int MEAS = 0;
  localparam int DIVD = 1;
  localparam logic [31:0] ONES = 32'hFFFF_FFFF;
  localparam int DRAIN_CYC = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic s_axis_tuser_i = 1'b0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [143:0] m_axis_tdata_o;
  logic m_axis_tuser_o;
  logic m_axis_tlast_o;
  logic cfg_we_i = 1'b0;
  logic cfg_addr_i = 1'b0;
  logic [FRAC_W-1:0] cfg_wdata_i = '0;

  damped_spectral_division dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // predictor state
  logic [16:0] damp_frac;
  logic [13:0] n_samples;
  logic [63:0] energy_acc;
  logic [63:0] damping;

  resp_t resp_q[$];
  int errors = 0;
  int n_sent = 0;
  int n_meas = 0;
  int n_resp = 0;
  int n_sat = 0;
  int n_zero = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int rx_hold = 0;

  function automatic logic [63:0] shift_div(input logic [63:0] a, input logic [63:0] b,
                                            input int s, output logic ovf);
    logic [63:0] q, r;
    logic carry;
    q = a / b;
    r = a % b;
    ovf = 1'b0;
    for (int i = 0; i < s; i++) begin
      carry = r[63];
      if (q[63]) begin
        ovf = 1'b1;
        return '1;
      end
      q = q << 1;
      r = r << 1;
      if (carry || r >= b) begin
        r = r - b;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint delay_phase(input longint x, input longint y);
    longint z, p, xs, ys;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? longint'(HALF_TURN) : -longint'(HALF_TURN);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < COR_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(atan_entry(5'(i)));
      end else if (y < 0) begin
        x -= ys; y += xs; z -= longint'(atan_entry(5'(i)));
      end
    end
    p = (-z + 256) >>> 9;
    if (p > PHASE_LIM) p = PHASE_LIM;
    if (p < -PHASE_LIM) p = -PHASE_LIM;
    return p;
  endfunction

  function automatic longint clip_part(input longint num, input logic [63:0] den,
                                       output logic sat);
    logic ovf;
    logic [63:0] q;
    q = shift_div(num < 0 ? 64'(-num) : 64'(num), den, 16, ovf);
    sat = 1'b0;
    if (num >= 0) begin
      if (ovf || q > 64'h7FFF_FFFF) begin
        sat = 1'b1;
        return 64'sh7FFF_FFFF;
      end
      return longint'(q);
    end
    if (ovf || q > 64'h8000_0000) begin
      sat = 1'b1;
      return -64'sh8000_0000;
    end
    return -longint'(q);
  endfunction

  // one accepted beat: updates the energy state or returns the response bin
  function automatic bit predict_bin(input bin_t b, output resp_t r);
    longint ir, ii, orl, oim, nr, ni, re, im;
    logic [63:0] ipow, opow, den, q, cnt, sq;
    logic [64:0] sum;
    logic [127:0] prod;
    logic s1, s2, ovf;
    ir = b.ir; ii = b.ii; orl = b.orl; oim = b.oim;
    ipow = 64'(ir * ir + ii * ii);
    r = '0;
    if (b.cmd == 1'(MEAS)) begin
      sum = {1'b0, energy_acc} + {1'b0, ipow};
      energy_acc = sum[64] ? '1 : sum[63:0];
      if (b.last) begin
        cnt = (n_samples == 0) ? 64'd1 : (n_samples > MAX_SAMPLES) ? 64'(MAX_SAMPLES)
                                                                    : 64'(n_samples);
        q = energy_acc / cnt;
        prod = 128'(q >> 16) * damp_frac + ((128'(q[15:0]) * damp_frac) >> 16);
        damping = (prod > 128'(64'hFFFF_FFFF_FFFF_FFFF)) ? '1 : prod[63:0];
        energy_acc = 0;
      end
      return 0;
    end
    nr = orl * ir + oim * ii;
    ni = oim * ir - orl * ii;
    opow = 64'(orl * orl + oim * oim);
    sum = {1'b0, ipow} + {1'b0, damping};
    den = sum[64] ? '1 : sum[63:0];
    re = 0; im = 0; s1 = 0; s2 = 0;
    if (den != 0) begin
      re = clip_part(nr, den, s1);
      im = clip_part(ni, den, s2);
      r.mag = (s1 || s2) ? ONES : 32'(int_sqrt(64'(re * re) + 64'(im * im)));
    end
    if (ipow == 0) begin
      r.zero = 1'b1;
      r.ratio = (opow != 0) ? ONES : '0;
    end else begin
      sq = shift_div(opow, ipow, 32, ovf);
      r.ratio = ovf ? ONES : 32'(int_sqrt(sq));
    end
    if (den == 0) r.zero = 1'b1;
    r.re = 32'(re);
    r.im = 32'(im);
    r.phase = 16'(delay_phase(nr, ni));
    r.last = b.last;
    return 1;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    if (errors <= 40)
      $display("%0t: %s got %0d want %0d (result %0d)", $realtime, what, got, want, n_resp);
  endtask

  // response checker
  always @(posedge clk_i) begin
    resp_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.re = m_axis_tdata_o[31:0];
      got.im = m_axis_tdata_o[63:32];
      got.mag = m_axis_tdata_o[95:64];
      got.phase = m_axis_tdata_o[111:96];
      got.ratio = m_axis_tdata_o[143:112];
      got.zero = m_axis_tuser_o;
      got.last = m_axis_tlast_o;
      if (resp_q.size() == 0) begin
        report("unexpected beat, resp_real", got.re, 0);
      end else begin
        want = resp_q.pop_front();
        if (got.re !== want.re) report("resp_real", got.re, want.re);
        if (got.im !== want.im) report("resp_imag", got.im, want.im);
        if (got.mag !== want.mag) report("resp_magnitude", got.mag, want.mag);
        if (got.phase !== want.phase) report("resp_phase", got.phase, want.phase);
        if (got.ratio !== want.ratio) report("direct_ratio", got.ratio, want.ratio);
        if (got.zero !== want.zero) report("zero_divisor", got.zero, want.zero);
        if (got.last !== want.last) report("last_out", got.last, want.last);
      end
      n_resp++;
    end
  end

  // receiver: random stalls plus a single long hold-off
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= rx_idle);
    end
  end

  task automatic send_bin(input bin_t b, input logic typed, input resp_t typed_r);
    resp_t r;
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {b.oim, b.orl, b.ii, b.ir};
    s_axis_tuser_i <= b.cmd;
    s_axis_tlast_i <= b.last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    n_sent++;
    if (predict_bin(b, r)) begin
      if (r.mag == ONES) n_sat++;
      if (r.zero) n_zero++;
      resp_q.push_back(typed ? typed_r : r);
    end else begin
      n_meas++;
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (resp_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic addr, input logic [FRAC_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == CFG_DAMP_FRAC) damp_frac = val;
    else n_samples = val[CNT_W-1:0];
    @(posedge clk_i);
  endtask

  function automatic logic signed [23:0] rand_coef();
    int w;
    logic signed [23:0] v;
    case ($urandom_range(5))
      0, 1: v = 24'($urandom);
      2: begin
        w = $urandom_range(1, 23);
        v = 24'($urandom_range(0, (1 << w) - 1));
        if ($urandom_range(1)) v = -v;
      end
      3: case ($urandom_range(4))
        0: v = 24'sh7FFFFF;
        1: v = 24'sh800000;
        2: v = 0;
        3: v = 1;
        default: v = -1;
      endcase
      default: begin
        v = 24'($urandom_range(0, 1 << 18));
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic bin_t rand_bin(input logic cmd, input logic last);
    bin_t b;
    b.cmd = cmd;
    b.last = last;
    b.ir = rand_coef();
    b.ii = rand_coef();
    b.orl = rand_coef();
    b.oim = rand_coef();
    if ($urandom_range(19) == 0) begin
      b.ir = 0;
      b.ii = 0;
    end
    return b;
  endfunction

  // well-formed measure/divide passes, with some stray and broken beats
  task automatic run_passes(input int n_items);
    int stop, nb;
    stop = n_sent + n_items;
    while (n_sent < stop) begin
      if ($urandom_range(99) < 15) begin
        send_bin(rand_bin(1'($urandom_range(1)), 1'($urandom_range(1))), 1'b0, '0);
      end else begin
        nb = $urandom_range(1, 6);
        for (int i = 0; i < nb; i++) send_bin(rand_bin(1'(MEAS), i == nb - 1), 1'b0, '0);
        for (int i = 0; i < nb; i++) send_bin(rand_bin(1'(DIVD), i == nb - 1), 1'b0, '0);
      end
    end
  endtask

  row_t dir_tab[] = '{
    '{'{1'b1, 24'sd0, 24'sd0, 24'sd1, 24'sd0, 1'b0}, 1'b1,
      '{32'sd0, 32'sd0, 32'd0, 16'sd0, ONES, 1'b1, 1'b0}},
    '{'{1'b1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b1,
      '{32'sd0, 32'sd0, 32'd0, 16'sd0, 32'd0, 1'b1, 1'b1}},
    '{'{1'b1, 24'sd65536, 24'sd0, 24'sd65536, 24'sd0, 1'b0}, 1'b1,
      '{32'sd65536, 32'sd0, 32'd65536, 16'sd0, 32'd65536, 1'b0, 1'b0}},
    '{'{1'b1, 24'sd65536, 24'sd0, -24'sd65536, 24'sd0, 1'b1}, 1'b1,
      '{-32'sd65536, 32'sd0, 32'd65536, -16'sd23040, 32'd65536, 1'b0, 1'b1}},
    '{'{1'b1, 24'sd65536, 24'sd0, 24'sd0, 24'sd0, 1'b0}, 1'b1,
      '{32'sd0, 32'sd0, 32'd0, 16'sd0, 32'd0, 1'b0, 1'b0}},
    '{'{1'b1, 24'sd1, 24'sd0, 24'sh7FFFFF, 24'sh7FFFFF, 1'b0}, 1'b0, '0},
    '{'{1'b1, 24'sh800000, 24'sh800000, 24'sh800000, 24'sh800000, 1'b0}, 1'b0, '0},
    '{'{1'b1, 24'sh7FFFFF, 24'sh800000, 24'sh800000, 24'sh7FFFFF, 1'b1}, 1'b0, '0},
    '{'{1'b1, 24'sh800000, 24'sd0, 24'sd1, 24'sh7FFFFF, 1'b0}, 1'b0, '0},
    '{'{1'b0, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 1'b0}, 1'b0, '0},
    '{'{1'b0, 24'sh800000, 24'sh800000, 24'sd0, 24'sd0, 1'b0}, 1'b0, '0},
    '{'{1'b0, 24'sd1, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 24'sd1, 24'sd1, 24'sh7FFFFF, 24'sd0, 1'b0}, 1'b0, '0},
    '{'{1'b1, 24'sd0, 24'sd0, 24'sd5, -24'sd3, 1'b0}, 1'b0, '0},
    '{'{1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sd1, 24'sd1, 1'b1}, 1'b0, '0},
    '{'{1'b0, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b1}, 1'b0, '0},
    '{'{1'b1, 24'sd0, 24'sd1, -24'sd1, 24'sd0, 1'b0}, 1'b0, '0}
  };

  initial begin
    #(8 * 4_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    damp_frac = DAMP_FRAC_RST;
    n_samples = SAMPLE_CNT_RST;
    energy_acc = 0;
    damping = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) send_bin(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].r);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_DAMP_FRAC, 17'd65536); write_reg(CFG_SAMPLE_CNT, 17'd1); end
        1: begin write_reg(CFG_DAMP_FRAC, 17'd0); write_reg(CFG_SAMPLE_CNT, 17'd8192); end
        2: begin write_reg(CFG_DAMP_FRAC, 17'd6554); write_reg(CFG_SAMPLE_CNT, 17'd0); end
        3: begin write_reg(CFG_DAMP_FRAC, 17'd1); write_reg(CFG_SAMPLE_CNT, 17'd16383); end
        default: begin
          write_reg(CFG_DAMP_FRAC, 17'($urandom_range(0, 65536)));
          write_reg(CFG_SAMPLE_CNT, 17'($urandom_range(0, 16383)));
        end
      endcase
      tx_idle = (ph < 2) ? 34 : (ph < 4) ? 77 : 0;
      rx_idle = (ph < 2) ? 77 : (ph < 4) ? 34 : 0;
      if (ph == 1) rx_hold = 3000;
      run_passes(255);
      drain();
    end

    $display("%0d beats in (%0d measure), %0d response bins out", n_sent, n_meas, n_resp);
    $display("%0d saturated magnitudes, %0d zero-divisor bins, %0d faults",
             n_sat, n_zero, errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
